// File: design/spt_pkg.sv
// Shared widths, codes and controller/datapath bundles for the sparse pattern transpose.
`timescale 1ns / 1ps
package spt_pkg;

	localparam int MAX_ROWS_DEF    = 1024;
	localparam int MAX_COLS_DEF    = 1024;
	localparam int MAX_ENTRIES_DEF = 4096;

	localparam int MODE_W     = 3;
	localparam int ROW_W      = 10;
	localparam int COL_W      = 10;
	localparam int INDEX_W    = 13;
	localparam int VAL_W      = 13;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIN   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RDST  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RDCOL = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLR   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNFIN = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'd1;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_ADDED,
		RES_FIN,
		RES_START,
		RES_TROW
	} res_sel_t;

	typedef struct packed {
		logic              load;
		logic              add_rd;
		logic              add_wr;
		logic              fin_init;
		logic              ps_rd;
		logic              ps_wr;
		logic              sc_rd;
		logic              sc_fp_rd;
		logic              sc_wr;
		logic              sc_skip;
		logic              fin_done;
		logic              rd_st;
		logic              rd_tr;
		logic              clr_start;
		logic              clr_step;
		logic              emit;
		res_sel_t          res;
		logic [STAT_W-1:0] status;
	} spt_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              add_range;
		logic              add_full;
		logic              unfin;
		logic              st_range;
		logic              tr_range;
		logic              nc_zero;
		logic              ps_last;
		logic              sc_done;
		logic              col_ok;
		logic              clr_last;
		logic              out_free;
	} spt_sts_t;

endpackage

// File: design/spt_item_if.sv
// Input channel carrying one command transaction.
`timescale 1ns / 1ps
interface spt_item_if import spt_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [ROW_W-1:0]   row;
	logic [COL_W-1:0]   col;
	logic [INDEX_W-1:0] index;
	modport source(output valid, mode, row, col, index, input ready);
	modport sink(input valid, mode, row, col, index, output ready);
endinterface

// File: design/spt_result_if.sv
// Output channel carrying one result transaction.
`timescale 1ns / 1ps
interface spt_result_if import spt_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  value;
	logic [STAT_W-1:0] status;
	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface

// File: design/spt_cfg_if.sv
// Configuration write channel carrying a register index and write data.
`timescale 1ns / 1ps
interface spt_cfg_if import spt_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: design/spt_datapath.sv
// Datapath with the entry, count, start, fill-position and transposed stores, counters and output register.
`timescale 1ns / 1ps
module spt_datapath import spt_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spt_cmd_t              cmd,
	output spt_sts_t              sts,
	input  logic [MODE_W-1:0]     in_mode,
	input  logic [ROW_W-1:0]      in_row,
	input  logic [COL_W-1:0]      in_col,
	input  logic [INDEX_W-1:0]    in_index,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	output logic [VAL_W-1:0]      out_value,
	output logic [STAT_W-1:0]     out_status,
	input  logic                  out_ready
);

	localparam int RL_W  = $clog2(MAX_ROWS + 1);
	localparam int CL_W  = $clog2(MAX_COLS + 1);
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [CFG_DATA_W-1:0] num_rows_q, num_cols_q;
	logic                  finished_q;
	logic [CNT_W-1:0]      total_q, ttot_q, acc_q, k_q;
	logic [CL_W-1:0]       c_q;
	logic                  out_valid_q;
	logic [VAL_W-1:0]      value_q;
	logic [STAT_W-1:0]     status_q;

	logic [MODE_W-1:0]  mode_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [INDEX_W-1:0] index_q;

	logic [CNT_W-1:0] cnt_mem [0:MAX_COLS-1];
	logic [CNT_W-1:0] st_mem  [0:MAX_COLS];
	logic [CNT_W-1:0] fp_mem  [0:MAX_COLS-1];
	logic [ROW_W-1:0] er_mem  [0:MAX_ENTRIES-1];
	logic [COL_W-1:0] ec_mem  [0:MAX_ENTRIES-1];
	logic [ROW_W-1:0] tr_mem  [0:MAX_ENTRIES-1];

	logic [CNT_W-1:0] cnt_rd_q, st_rd_q, fp_rd_q;
	logic [ROW_W-1:0] er_rd_q, tr_rd_q;
	logic [COL_W-1:0] ec_rd_q;

	logic [RL_W-1:0]  rl;
	logic [CL_W-1:0]  nc;
	logic [CNT_W-1:0] sum, fp_next;
	logic [CW-1:0]    c_addr, col_addr, ec_addr;
	logic [VAL_W-1:0] res_value;

	assign rl = (num_rows_q >= MAX_ROWS) ? RL_W'(MAX_ROWS) : RL_W'(num_rows_q);
	assign nc = (num_cols_q >= MAX_COLS) ? CL_W'(MAX_COLS) : CL_W'(num_cols_q);
	assign sum      = acc_q + cnt_rd_q;
	assign fp_next  = fp_rd_q + 1'b1;
	assign c_addr   = c_q[CW-1:0];
	assign col_addr = CW'(col_q);
	assign ec_addr  = CW'(ec_rd_q);

	always_comb begin
		sts.mode      = mode_q;
		sts.add_range = (row_q >= rl) || (col_q >= nc);
		sts.add_full  = total_q == CNT_W'(MAX_ENTRIES);
		sts.unfin     = !finished_q;
		sts.st_range  = index_q > nc;
		sts.tr_range  = (index_q >= ttot_q) || (index_q >= MAX_ENTRIES);
		sts.nc_zero   = nc == '0;
		sts.ps_last   = ({1'b0, c_q} + 1'b1) == {1'b0, nc};
		sts.sc_done   = k_q >= total_q;
		sts.col_ok    = ec_rd_q < nc;
		sts.clr_last  = c_q == CL_W'(MAX_COLS - 1);
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		case (cmd.res)
			RES_ZERO:  res_value = '0;
			RES_ADDED: res_value = VAL_W'(total_q + 1'b1);
			RES_FIN:   res_value = VAL_W'(acc_q);
			RES_START: res_value = VAL_W'(st_rd_q);
			RES_TROW:  res_value = VAL_W'(tr_rd_q);
			default:   res_value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= '0;
			num_cols_q  <= '0;
			finished_q  <= 1'b0;
			total_q     <= '0;
			ttot_q      <= '0;
			acc_q       <= '0;
			k_q         <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_NUM_ROWS: num_rows_q <= cfg_data;
					CFG_NUM_COLS: num_cols_q <= cfg_data;
					default: ;
				endcase
				finished_q <= 1'b0;
			end
			if (cmd.add_wr) begin
				total_q    <= total_q + 1'b1;
				finished_q <= 1'b0;
			end
			if (cmd.clr_start) begin
				total_q    <= '0;
				finished_q <= 1'b0;
				c_q        <= '0;
			end
			if (cmd.clr_step) begin
				c_q <= c_q + 1'b1;
			end
			if (cmd.fin_init) begin
				acc_q <= '0;
				c_q   <= '0;
				k_q   <= '0;
			end
			if (cmd.ps_wr) begin
				acc_q <= sum;
				c_q   <= c_q + 1'b1;
			end
			if (cmd.sc_wr || cmd.sc_skip) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.fin_done) begin
				finished_q <= 1'b1;
				ttot_q     <= acc_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_mode;
			row_q   <= in_row;
			col_q   <= in_col;
			index_q <= in_index;
		end
		if (cmd.emit) begin
			value_q  <= res_value;
			status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr || cmd.clr_step) begin
			cnt_mem[cmd.add_wr ? col_addr : c_addr] <= cmd.add_wr ? cnt_rd_q + 1'b1 : '0;
		end
		if (cmd.add_rd || cmd.ps_rd) begin
			cnt_rd_q <= cnt_mem[cmd.add_rd ? col_addr : c_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_init || cmd.ps_wr) begin
			st_mem[cmd.fin_init ? '0 : CL_W'(c_q + 1'b1)] <= cmd.fin_init ? '0 : sum;
		end
		if (cmd.rd_st) begin
			st_rd_q <= st_mem[CL_W'(index_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ps_wr || cmd.sc_wr) begin
			fp_mem[cmd.ps_wr ? c_addr : ec_addr] <= cmd.ps_wr ? acc_q : fp_next;
		end
		if (cmd.sc_fp_rd) begin
			fp_rd_q <= fp_mem[ec_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			er_mem[total_q[EW-1:0]] <= row_q;
			ec_mem[total_q[EW-1:0]] <= col_q;
		end
		if (cmd.sc_rd) begin
			er_rd_q <= er_mem[k_q[EW-1:0]];
			ec_rd_q <= ec_mem[k_q[EW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sc_wr && (fp_rd_q < MAX_ENTRIES)) begin
			tr_mem[fp_rd_q[EW-1:0]] <= er_rd_q;
		end
		if (cmd.rd_tr) begin
			tr_rd_q <= tr_mem[EW'(index_q)];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = value_q;
	assign out_status = status_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_ENTRIES))
		else $error("Entry total exceeds the store size.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("Result written over a pending transaction.");

	a_fin_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_done |=> (finished_q && ttot_q <= total_q))
		else $error("Finish total larger than the entry total.");

	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |-> !sts.add_full)
		else $error("Entry written into a full store.");

endmodule

// File: design/spt_ctrl.sv
// Controller state machine sequencing add, finish, read and clear operations.
`timescale 1ns / 1ps
module spt_ctrl import spt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  spt_sts_t sts,
	output spt_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_RST_CLR,
		S_IDLE,
		S_DECODE,
		S_ADD_WR,
		S_PS_RD,
		S_PS_WR,
		S_SC_CHK,
		S_SC_FP,
		S_SC_WR,
		S_RD_OUT,
		S_CLR
	} state_t;

	state_t state_q, state_nx;

	assign in_ready = (state_q == S_IDLE) && sts.out_free;

	always_comb begin
		cmd      = '0;
		cmd.res  = RES_ZERO;
		state_nx = state_q;
		case (state_q)
			S_RST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nx = S_IDLE;
				case (sts.mode)
					MODE_ADD: begin
						if (sts.add_range) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_RANGE;
						end else if (sts.add_full) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_FULL;
						end else begin
							cmd.add_rd = 1'b1;
							state_nx   = S_ADD_WR;
						end
					end
					MODE_FIN: begin
						cmd.fin_init = 1'b1;
						state_nx     = sts.nc_zero ? S_SC_CHK : S_PS_RD;
					end
					MODE_RDST: begin
						if (sts.unfin) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_UNFIN;
						end else if (sts.st_range) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_RANGE;
						end else begin
							cmd.rd_st = 1'b1;
							state_nx  = S_RD_OUT;
						end
					end
					MODE_RDCOL: begin
						if (sts.unfin) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_UNFIN;
						end else if (sts.tr_range) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_RANGE;
						end else begin
							cmd.rd_tr = 1'b1;
							state_nx  = S_RD_OUT;
						end
					end
					MODE_CLR: begin
						cmd.clr_start = 1'b1;
						state_nx      = S_CLR;
					end
					default: ;
				endcase
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				cmd.emit   = 1'b1;
				cmd.res    = RES_ADDED;
				cmd.status = ST_OK;
				state_nx   = S_IDLE;
			end
			S_PS_RD: begin
				cmd.ps_rd = 1'b1;
				state_nx  = S_PS_WR;
			end
			S_PS_WR: begin
				cmd.ps_wr = 1'b1;
				state_nx  = sts.ps_last ? S_SC_CHK : S_PS_RD;
			end
			S_SC_CHK: begin
				if (sts.sc_done) begin
					cmd.fin_done = 1'b1;
					cmd.emit     = 1'b1;
					cmd.res      = RES_FIN;
					cmd.status   = ST_OK;
					state_nx     = S_IDLE;
				end else begin
					cmd.sc_rd = 1'b1;
					state_nx  = S_SC_FP;
				end
			end
			S_SC_FP: begin
				if (sts.col_ok) begin
					cmd.sc_fp_rd = 1'b1;
					state_nx     = S_SC_WR;
				end else begin
					cmd.sc_skip = 1'b1;
					state_nx    = S_SC_CHK;
				end
			end
			S_SC_WR: begin
				cmd.sc_wr = 1'b1;
				state_nx  = S_SC_CHK;
			end
			S_RD_OUT: begin
				cmd.emit   = 1'b1;
				cmd.res    = (sts.mode == MODE_RDST) ? RES_START : RES_TROW;
				cmd.status = ST_OK;
				state_nx   = S_IDLE;
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.emit   = 1'b1;
					cmd.status = ST_OK;
					state_nx   = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// File: design/sparse_pattern_transpose_top.sv
// Top level of the compressed-row sparse pattern transpose.
//
// Channel     Direction  Fields
// item_in     sink       mode, row, col, index
// result_out  source     value, status
// cfg         sink       index, data
//
// A finish runs a single-port walk over the count and fill-position memories.
// After reset a clearing pass zeroes the column counts with item_in.ready low;
// cfg is always ready. One transaction is in work at a time, and a new one is
// taken only once the output register is empty or being emptied.
`timescale 1ns / 1ps
module sparse_pattern_transpose_top import spt_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_COLS    = MAX_COLS_DEF,
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	spt_item_if.sink      item_in,
	spt_result_if.source  result_out,
	spt_cfg_if.sink       cfg
);

	spt_cmd_t cmd;
	spt_sts_t sts;

	assign cfg.ready = 1'b1;

	spt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (item_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spt_datapath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (item_in.mode),
		.in_row     (item_in.row),
		.in_col     (item_in.col),
		.in_index   (item_in.index),
		.cfg_we     (cfg.valid),
		.cfg_idx    (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (result_out.valid),
		.out_value  (result_out.value),
		.out_status (result_out.status),
		.out_ready  (result_out.ready)
	);

endmodule
